// ----- rtl/wsd_pkg.sv -----
// Package for the WebSocket frame deframer.
// Holds the result kind codes, the phase codes and the field widths.
// No dependencies.
package wsd_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned KindW   = 2;
    localparam int unsigned OpcodeW = 4;
    localparam int unsigned LenW    = 16;
    localparam int unsigned PhaseW  = 3;

    typedef logic [ByteW-1:0]   t_byte;
    typedef logic [KindW-1:0]   t_kind;
    typedef logic [OpcodeW-1:0] t_opcode;
    typedef logic [LenW-1:0]    t_len;
    typedef logic [PhaseW-1:0]  t_phase;

    localparam t_kind KIND_PAYLOAD = 2'd0;
    localparam t_kind KIND_EMPTY   = 2'd1;
    localparam t_kind KIND_ERROR   = 2'd2;

    localparam t_phase PH_HDR0    = 3'd0;
    localparam t_phase PH_HDR1    = 3'd1;
    localparam t_phase PH_EXT_HI  = 3'd2;
    localparam t_phase PH_EXT_LO  = 3'd3;
    localparam t_phase PH_MASK    = 3'd4;
    localparam t_phase PH_PAYLOAD = 3'd5;
    localparam t_phase PH_ERROR   = 3'd6;

    localparam t_byte   MASK_BIT  = 8'h80;
    localparam t_byte   LEN7_MASK = 8'h7F;
    localparam t_byte   LEN_EXT16 = 8'd126;
    localparam t_byte   LEN_EXT64 = 8'd127;
    localparam t_opcode OPC_MASK  = 4'hF;

endpackage

// ----- rtl/wsd_if.sv -----
// Valid/ready channel interfaces for the WebSocket frame deframer.
// wsd_byte_if carries raw stream bytes; wsd_result_if carries result requests.
// Depends on wsd_pkg.
interface wsd_byte_if;
    import wsd_pkg::*;

    logic  valid;
    logic  ready;
    t_byte stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_result_if;
    import wsd_pkg::*;

    logic    valid;
    logic    ready;
    t_kind   kind;
    t_byte   payload_byte;
    t_opcode frame_opcode;
    logic    last_in_frame;

    modport source (output valid, output kind, output payload_byte,
                    output frame_opcode, output last_in_frame, input ready);
    modport sink   (input valid, input kind, input payload_byte,
                    input frame_opcode, input last_in_frame, output ready);
endinterface

// ----- rtl/websocket_frame_deframer.sv -----
// WebSocket client frame deframer and unmasker, top level.
// Depends on wsd_pkg and the channel interfaces in wsd_if.sv.
//
// Usage:
//   i_in  : one raw stream byte per request (valid/ready).
//   o_out : one result request per payload byte, one empty-frame marker per
//           zero-length frame, one error request on an unmasked frame or a
//           64-bit length. Other header, length and mask bytes give no result.
//   Output: a result is registered and appears on o_out in the cycle after its byte is accepted.
//   Throughput: one byte per cycle while no stalled result blocks input; each byte
//   passes through the phase logic combinationally and results land in the result register.
//   Stall: i_in.ready stays high while the result register is empty or is
//   being taken in the same cycle; a stalled result holds and blocks input.
//   Reset (i_rst_n low, synchronous): parser returns to the first header
//   byte, opcode, length, mask and counter clear, result register empties.
//   After an error the block drops every byte silently until reset.
module websocket_frame_deframer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wsd_byte_if.sink            i_in,
    wsd_result_if.source        o_out
);
    import wsd_pkg::*;

    t_phase          r_phase,  n_phase;
    t_opcode         r_opcode, n_opcode;
    t_len            r_len,    n_len;
    logic [31:0]     r_mask,   n_mask;
    t_len            r_count,  n_count;

    logic            r_out_valid;
    t_kind           r_kind,   n_kind;
    t_byte           r_data,   n_data;
    t_opcode         r_out_opc;
    logic            r_last,   n_last;
    logic            n_emit;

    logic            accept;
    t_byte           b;
    t_byte           len7;
    t_byte           key;
    t_len            count_inc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.stream_byte;
    assign len7       = b & LEN7_MASK;
    assign count_inc  = r_count + t_len'(1);

    always_comb begin
        case (r_count[1:0])
            2'd0:    key = r_mask[31:24];
            2'd1:    key = r_mask[23:16];
            2'd2:    key = r_mask[15:8];
            default: key = r_mask[7:0];
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_len    = r_len;
        n_mask   = r_mask;
        n_count  = r_count;
        n_emit   = 1'b0;
        n_kind   = KIND_PAYLOAD;
        n_data   = '0;
        n_last   = 1'b0;
        case (r_phase)
            PH_HDR0: begin
                n_opcode = b[OpcodeW-1:0] & OPC_MASK;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                if ((b & MASK_BIT) == '0 || len7 == LEN_EXT64) begin
                    n_phase = PH_ERROR;
                    n_emit  = 1'b1;
                    n_kind  = KIND_ERROR;
                end else if (len7 == LEN_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else begin
                    n_len   = t_len'(len7);
                    n_count = '0;
                    n_phase = PH_MASK;
                end
            end
            PH_EXT_HI: begin
                n_len   = {b, 8'h00};
                n_phase = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_len   = {r_len[15:8], b};
                n_count = '0;
                n_phase = PH_MASK;
            end
            PH_MASK: begin
                n_mask  = {r_mask[23:0], b};
                n_count = count_inc;
                if (r_count[1:0] == 2'd3) begin
                    n_count = '0;
                    if (r_len == '0) begin
                        n_phase = PH_HDR0;
                        n_emit  = 1'b1;
                        n_kind  = KIND_EMPTY;
                        n_last  = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_count = count_inc;
                n_emit  = 1'b1;
                n_kind  = KIND_PAYLOAD;
                n_data  = b ^ key;
                n_last  = (count_inc == r_len);
                if (count_inc == r_len) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_opcode    <= '0;
            r_len       <= '0;
            r_mask      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_opcode <= n_opcode;
                r_len    <= n_len;
                r_mask   <= n_mask;
                r_count  <= n_count;
            end
            if (accept) begin
                r_out_valid <= n_emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_kind    <= n_kind;
            r_data    <= n_data;
            r_out_opc <= n_opcode;
            r_last    <= n_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.payload_byte  = r_data;
    assign o_out.frame_opcode  = r_out_opc;
    assign o_out.last_in_frame = r_last;

endmodule

// ----- sim/tb.sv -----
// Testbench for websocket_frame_deframer: streams masked client frames and checks each
// result against a frame parser model kept in the bench. Sender gaps and receiver stalls are random.
// Depends on rtl/wsd_pkg.sv, rtl/wsd_if.sv and rtl/websocket_frame_deframer.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    typedef struct packed {
        t_kind   kind;
        t_byte   data;
        t_opcode opcode;
        logic    last;
    } t_frame_result;

    logic i_clk;
    logic i_rst_n;

    wsd_byte_if   in_if ();
    wsd_result_if out_if ();

    websocket_frame_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_phase      cur_phase  = PH_HDR0;
    t_opcode     cur_opcode = '0;
    t_len        frame_len  = '0;
    logic [31:0] mask_key   = '0;
    t_len        byte_idx   = '0;

    t_frame_result result_q[$];
    t_frame_result want;
    t_frame_result got;
    int unsigned   fail_count = 0;
    int unsigned   bytes_sent = 0;
    int unsigned   burst_left = 0;
    int unsigned   hold_left  = 0;
    int unsigned   stall_mode = 0;
    int unsigned   rx_cycle   = 0;
    bit            hold_req   = 1'b0;

    function automatic bit deframe_byte(input t_byte b, output t_frame_result r);
        t_byte key;
        bit    last;
        r = '0;
        deframe_byte = 1'b0;
        case (cur_phase)
            PH_HDR0: begin
                cur_opcode = b[OpcodeW-1:0] & OPC_MASK;
                cur_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                if ((b & MASK_BIT) == '0 || (b & LEN7_MASK) == LEN_EXT64) begin
                    cur_phase = PH_ERROR;
                    r = '{kind: KIND_ERROR, data: '0, opcode: cur_opcode, last: 1'b0};
                    deframe_byte = 1'b1;
                end else if ((b & LEN7_MASK) == LEN_EXT16) begin
                    cur_phase = PH_EXT_HI;
                end else begin
                    frame_len = t_len'(b & LEN7_MASK);
                    byte_idx  = '0;
                    cur_phase = PH_MASK;
                end
            end
            PH_EXT_HI: begin
                frame_len = {b, 8'h00};
                cur_phase = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                frame_len = frame_len | t_len'(b);
                byte_idx  = '0;
                cur_phase = PH_MASK;
            end
            PH_MASK: begin
                mask_key = {mask_key[23:0], b};
                byte_idx = byte_idx + 1'b1;
                if (byte_idx >= 4) begin
                    byte_idx = '0;
                    if (frame_len == '0) begin
                        cur_phase = PH_HDR0;
                        r = '{kind: KIND_EMPTY, data: '0, opcode: cur_opcode, last: 1'b1};
                        deframe_byte = 1'b1;
                    end else begin
                        cur_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                key      = mask_key[8*(3-byte_idx[1:0]) +: 8];
                byte_idx = byte_idx + 1'b1;
                last     = (byte_idx == frame_len);
                if (last) begin
                    cur_phase = PH_HDR0;
                end
                r = '{kind: KIND_PAYLOAD, data: b ^ key, opcode: cur_opcode, last: last};
                deframe_byte = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

    // receiver: random stall modes, plus one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (rx_cycle % 50 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            if (hold_left == 0 && hold_req) begin
                hold_left = 300;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= (rx_cycle % 4 != 0);
                    default: out_if.ready <= (rx_cycle % 5 == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{kind: out_if.kind, data: out_if.payload_byte,
                    opcode: out_if.frame_opcode, last: out_if.last_in_frame};
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%02h opcode=%0h last=%0d",
                         $time, got.kind, got.data, got.opcode, got.last);
                fail_count++;
            end else begin
                want = result_q.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.opcode !== want.opcode || got.last !== want.last) begin
                    $display("%0t: mismatch expected kind=%0d data=%02h opcode=%0h last=%0d",
                             $time, want.kind, want.data, want.opcode, want.last);
                    $display("%0t:          actual   kind=%0d data=%02h opcode=%0h last=%0d",
                             $time, got.kind, got.data, got.opcode, got.last);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_byte(input t_byte b);
        t_frame_result r;
        in_if.valid       <= 1'b1;
        in_if.stream_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (deframe_byte(b, r)) begin
            result_q.push_back(r);
        end
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 20);
        end
    endtask

    task automatic send_frame(input t_byte hdr0, input t_len len, input bit ext16,
                              input logic [31:0] key, input int fill);
        send_byte(hdr0);
        if (ext16 || len > 125) begin
            send_byte(MASK_BIT | LEN_EXT16);
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end else begin
            send_byte(MASK_BIT | t_byte'(len));
        end
        for (int i = 0; i < 4; i++) send_byte(key[31-8*i -: 8]);
        for (int i = 0; i < len; i++) send_byte(fill < 0 ? t_byte'($urandom) : t_byte'(fill));
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic test_empty_frames();
        send_frame(8'hFF, 16'd0, 1'b0, 32'hFFFF_FFFF, -1);
        send_frame(8'h00, 16'd0, 1'b1, 32'h0000_0000, -1);
    endtask

    task automatic test_short_extended_length();
        send_frame(8'h81, 16'd2, 1'b1, 32'h5A3C_C3A5, 8'h00);
        send_frame(8'h72, 16'd1, 1'b0, 32'hFFFF_FFFF, 8'hFF);
    endtask

    task automatic test_max_short_length();
        send_frame(t_byte'($urandom), 16'd125, 1'b0, $urandom, -1);
    endtask

    task automatic test_random_frames(input int unsigned n_bytes);
        int unsigned stop_at;
        t_len        len;
        bit          ext16;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            ext16 = 1'b0;
            case ($urandom_range(0, 9))
                0:       len = 16'd0;
                1, 2, 3,
                4:       len = t_len'($urandom_range(1, 8));
                5, 6:    len = t_len'($urandom_range(9, 40));
                7:       len = t_len'($urandom_range(100, 125));
                8: begin
                    ext16 = 1'b1;
                    len   = t_len'($urandom_range(0, 130));
                end
                default: begin
                    ext16 = 1'b1;
                    len   = t_len'($urandom_range(126, 300));
                end
            endcase
            send_frame(t_byte'($urandom), len, ext16, $urandom, -1);
        end
    endtask

    task automatic test_result_backpressure();
        hold_req = 1'b1;
        send_frame(t_byte'($urandom), 16'd60, 1'b0, $urandom, -1);
    endtask

    task automatic test_pause_until_drained();
        drain_results();
        send_frame(t_byte'($urandom), 16'd20, 1'b0, $urandom, -1);
        drain_results();
        send_frame(t_byte'($urandom), 16'd0, 1'b0, $urandom, -1);
    endtask

    task automatic test_protocol_error();
        send_byte(t_byte'($urandom));
        case ($urandom_range(0, 2))
            0:       send_byte(t_byte'($urandom_range(0, 126)));
            1:       send_byte(MASK_BIT | LEN_EXT64);
            default: send_byte(LEN_EXT64);
        endcase
        repeat (30) send_byte(t_byte'($urandom));
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.stream_byte <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_frames();
        test_short_extended_length();
        test_max_short_length();
        test_random_frames(600);
        test_result_backpressure();
        test_pause_until_drained();
        test_random_frames(500);
        test_protocol_error();

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/wsd_pkg.sv
rtl/wsd_if.sv
rtl/websocket_frame_deframer.sv
sim/tb.sv
